// ===== sv/sgp_pkg.sv =====
// Shared types and constants for the stereo goniometer plotter.
`default_nettype none

package sgp_pkg;

    localparam int SampleW = 32;
    localparam int PeakW   = 31;
    localparam int QuotW   = 17;
    localparam int NormW   = 18;
    localparam int GainW   = 20;
    localparam int ProdW   = QuotW + GainW;
    localparam int ShiftQ  = 30;
    localparam int DivSteps = 17;

    // full scale in Q1.15
    localparam logic [QuotW-1:0] Unit = 17'd32768;
    // 0.7071 in Q15 times the radius of 28
    localparam logic [GainW-1:0] AxisGain = 20'd648760;
    localparam logic [6:0] CentreX = 7'd63;
    localparam logic signed [7:0] CentreY = 8'sd31;
    localparam logic [8:0] MaxDist = 9'd16;

    // register indexes on the configuration port
    localparam logic CfgPeakLeft  = 1'b0;
    localparam logic CfgPeakRight = 1'b1;

    typedef struct packed {
        logic [6:0]        x;
        logic signed [7:0] y;
        logic              last;
    } point_t;

endpackage

`default_nettype wire

// ===== sv/stereo_goniometer_plotter_top.sv =====
// Top level of the stereo goniometer plotter: configuration registers and the front/back pipeline.
// A new sample pair is taken only after the last one is pushed; the pace is set by the 17-step
//   restoring dividers (one per channel, in parallel) plus normalize, multiply and hand-off steps.
// Path: the taken word is divided, normalized, multiplied, queued, then registered for out_valid.
// Reset (rst_n low, asynchronous): peaks return to 1, previous point is cleared,
//   queue and result register are emptied.
`default_nettype none

module stereo_goniometer_plotter_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [30:0]          cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [31:0]   left_sample,
    input  wire logic signed [31:0]   right_sample,
    input  wire logic                 last_in_frame,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      draw_line,
    output logic [6:0]                start_x,
    output logic signed [7:0]         start_y,
    output logic [6:0]                end_x,
    output logic signed [7:0]         end_y,
    output logic                      frame_end
);

    logic [sgp_pkg::PeakW-1:0] peak_left_reg, peak_right_reg;

    logic            f_valid, f_ready;
    sgp_pkg::point_t f_pt;
    logic            b_valid, b_ready;
    sgp_pkg::point_t b_pt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_left_reg  <= 31'd1;
            peak_right_reg <= 31'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sgp_pkg::CfgPeakLeft:  peak_left_reg  <= cfg_data;
                sgp_pkg::CfgPeakRight: peak_right_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    sgp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .left_sample   (left_sample),
        .right_sample  (right_sample),
        .last_in_frame (last_in_frame),
        .peak_left     (peak_left_reg),
        .peak_right    (peak_right_reg),
        .pt_valid      (f_valid),
        .pt_ready      (f_ready),
        .pt            (f_pt)
    );

    sgp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_pt),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_pt)
    );

    sgp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pt_valid  (b_valid),
        .pt_ready  (b_ready),
        .pt        (b_pt),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .draw_line (draw_line),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .frame_end (frame_end)
    );

endmodule

`default_nettype wire

// ===== sv/sgp_front.sv =====
// Front end: accepts sample pairs, normalizes both channels and maps them to a pixel.
`default_nettype none

module sgp_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [31:0]            left_sample,
    input  wire logic signed [31:0]            right_sample,
    input  wire logic                          last_in_frame,
    input  wire logic [sgp_pkg::PeakW-1:0]     peak_left,
    input  wire logic [sgp_pkg::PeakW-1:0]     peak_right,
    output logic                               pt_valid,
    input  wire logic                          pt_ready,
    output sgp_pkg::point_t                    pt
);

    // state vector: idle, divide, normalize, multiply, push
    logic [2:0] state_reg, state_next;
    localparam logic [2:0] SIdle = 3'd0;
    localparam logic [2:0] SDiv  = 3'd1;
    localparam logic [2:0] SNorm = 3'd2;
    localparam logic [2:0] SMul  = 3'd3;
    localparam logic [2:0] SPush = 3'd4;

    logic [4:0] step_reg;

    logic [sgp_pkg::PeakW-1:0]  div_reg [2];
    logic [sgp_pkg::PeakW-1:0]  rem_reg [2];
    logic [sgp_pkg::QuotW-1:0]  low_reg [2];
    logic [sgp_pkg::QuotW-1:0]  quo_reg [2];
    logic                       neg_reg [2];
    logic                       sat_reg [2];
    logic                       last_reg;

    logic signed [sgp_pkg::NormW-1:0] diff_reg, sum_reg;
    logic [sgp_pkg::ProdW-1:0]        prod_x_reg, prod_y_reg;
    logic                             neg_x_reg, neg_y_reg;

    // accept-cycle values
    logic [31:0]               smp  [2];
    logic [sgp_pkg::PeakW-1:0] pin  [2];
    logic [31:0]               mag  [2];
    logic [sgp_pkg::PeakW-1:0] pdiv [2];
    logic                      sat  [2];

    // divide step
    logic [31:0] trial [2];
    logic [31:0] tsub  [2];
    logic        tge   [2];

    // normalize
    logic [sgp_pkg::QuotW-1:0]        qsat [2];
    logic signed [sgp_pkg::NormW-1:0] nval [2];

    // multiply
    logic [sgp_pkg::NormW-1:0] dabs, sabs;

    // pixel
    logic [6:0] rx, ry;

    logic accept;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == SIdle);
    assign pt_valid = (state_reg == SPush);

    always_comb
    begin
        smp[0] = left_sample;
        smp[1] = right_sample;
        pin[0] = peak_left;
        pin[1] = peak_right;
        for (int c = 0; c < 2; c++)
        begin
            mag[c]  = smp[c][31] ? (~smp[c] + 32'd1) : smp[c];
            pdiv[c] = (pin[c] == '0) ? 31'd1 : pin[c];
            // quotient would reach 2^17 or more: saturate without dividing
            sat[c]  = {1'b0, mag[c]} >= {pdiv[c], 2'b00};

            trial[c] = {rem_reg[c], low_reg[c][sgp_pkg::QuotW-1]};
            tge[c]   = trial[c] >= {1'b0, div_reg[c]};
            tsub[c]  = trial[c] - {1'b0, div_reg[c]};

            qsat[c] = (sat_reg[c] || quo_reg[c] > sgp_pkg::Unit) ? sgp_pkg::Unit : quo_reg[c];
            nval[c] = neg_reg[c] ? -$signed({1'b0, qsat[c]}) : $signed({1'b0, qsat[c]});
        end
    end

    assign dabs = diff_reg[sgp_pkg::NormW-1] ? -diff_reg : diff_reg;
    assign sabs = sum_reg[sgp_pkg::NormW-1] ? -sum_reg : sum_reg;

    assign rx = prod_x_reg[sgp_pkg::ProdW-1:sgp_pkg::ShiftQ];
    assign ry = prod_y_reg[sgp_pkg::ProdW-1:sgp_pkg::ShiftQ];

    always_comb
    begin
        pt.last = last_reg;
        pt.x    = neg_x_reg ? (sgp_pkg::CentreX - rx) : (sgp_pkg::CentreX + rx);
        pt.y    = neg_y_reg ? (sgp_pkg::CentreY + $signed({1'b0, ry}))
                            : (sgp_pkg::CentreY - $signed({1'b0, ry}));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SIdle:
                if (accept)
                    state_next = SDiv;
            SDiv:
                if (step_reg == 5'(sgp_pkg::DivSteps - 1))
                    state_next = SNorm;
            SNorm:
                state_next = SMul;
            SMul:
                state_next = SPush;
            SPush:
                if (pt_ready)
                    state_next = SIdle;
            default:
                state_next = SIdle;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SIdle;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == SDiv)
                step_reg <= step_reg + 5'd1;
            else
                step_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg <= last_in_frame;
            for (int c = 0; c < 2; c++)
            begin
                neg_reg[c] <= smp[c][31];
                sat_reg[c] <= sat[c];
                div_reg[c] <= pdiv[c];
                rem_reg[c] <= {1'b0, mag[c][31:2]};
                low_reg[c] <= {mag[c][1:0], 15'd0};
                quo_reg[c] <= '0;
            end
        end
        else if (state_reg == SDiv)
        begin
            for (int c = 0; c < 2; c++)
            begin
                low_reg[c] <= {low_reg[c][sgp_pkg::QuotW-2:0], 1'b0};
                if (tge[c])
                begin
                    rem_reg[c] <= tsub[c][sgp_pkg::PeakW-1:0];
                    quo_reg[c] <= {quo_reg[c][sgp_pkg::QuotW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[c] <= trial[c][sgp_pkg::PeakW-1:0];
                    quo_reg[c] <= {quo_reg[c][sgp_pkg::QuotW-2:0], 1'b0};
                end
            end
        end

        if (state_reg == SNorm)
        begin
            diff_reg <= nval[0] - nval[1];
            sum_reg  <= nval[0] + nval[1];
        end

        if (state_reg == SMul)
        begin
            neg_x_reg  <= diff_reg[sgp_pkg::NormW-1];
            neg_y_reg  <= sum_reg[sgp_pkg::NormW-1];
            prod_x_reg <= dabs[sgp_pkg::QuotW-1:0] * sgp_pkg::AxisGain;
            prod_y_reg <= sabs[sgp_pkg::QuotW-1:0] * sgp_pkg::AxisGain;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sgp_queue.sv =====
// Two-word queue carrying pixel points from the front end to the back end.
`default_nettype none

module sgp_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_valid,
    output logic                 wr_ready,
    input  wire sgp_pkg::point_t wr_data,
    output logic                 rd_valid,
    input  wire logic            rd_ready,
    output sgp_pkg::point_t      rd_data
);

    sgp_pkg::point_t mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wptr_reg <= ~wptr_reg;
            if (pop)
                rptr_reg <= ~rptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

// ===== sv/sgp_back.sv =====
// Back end: decides line or pixel against the previous point and holds the result word.
`default_nettype none

module sgp_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              pt_valid,
    output logic                   pt_ready,
    input  wire sgp_pkg::point_t   pt,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   draw_line,
    output logic [6:0]             start_x,
    output logic signed [7:0]      start_y,
    output logic [6:0]             end_x,
    output logic signed [7:0]      end_y,
    output logic                   frame_end
);

    logic              have_prev_reg;
    logic [6:0]        prev_x_reg;
    logic signed [7:0] prev_y_reg;
    logic              out_valid_reg;

    logic signed [8:0] dx, dy;
    logic [7:0]        adx, ady;
    logic [8:0]        manhattan;
    logic              line;
    logic              pop;

    assign pt_ready  = !out_valid_reg || out_ready;
    assign pop       = pt_valid && pt_ready;
    assign out_valid = out_valid_reg;

    assign dx        = $signed({2'b00, pt.x}) - $signed({2'b00, prev_x_reg});
    assign dy        = $signed({pt.y[7], pt.y}) - $signed({prev_y_reg[7], prev_y_reg});
    assign adx       = dx[8] ? 8'(-dx) : dx[7:0];
    assign ady       = dy[8] ? 8'(-dy) : dy[7:0];
    assign manhattan = {1'b0, adx} + {1'b0, ady};
    assign line      = have_prev_reg && (manhattan <= sgp_pkg::MaxDist);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            have_prev_reg <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                // forget the previous point once the frame closes
                have_prev_reg <= !pt.last;
                prev_x_reg    <= pt.last ? 7'd0 : pt.x;
                prev_y_reg    <= pt.last ? 8'sd0 : pt.y;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            draw_line <= line;
            start_x   <= line ? prev_x_reg : 7'd0;
            start_y   <= line ? prev_y_reg : 8'sd0;
            end_x     <= pt.x;
            end_y     <= pt.y;
            frame_end <= pt.last;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the stereo goniometer plotter: directed table, random walk, stalls.
`default_nettype none

module tb_top;

    localparam int          CycleLimit   = 500_000;
    localparam int          DrainCycles  = 40;
    localparam int          RandPerPhase = 110;
    localparam int          NumPhases    = 8;
    localparam longint      RotGain      = 23170 * 28;
    localparam longint      QUnit        = 32768;
    localparam int          LineReach    = 16;
    localparam logic signed [31:0] SampleMax = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SampleMin = 32'sh8000_0000;
    localparam logic [30:0] PeakMax      = 31'h7FFF_FFFF;

    typedef struct packed {
        logic              draw_line;
        logic [6:0]        start_x;
        logic signed [7:0] start_y;
        logic [6:0]        end_x;
        logic signed [7:0] end_y;
        logic              frame_end;
    } plot_word_t;

    typedef struct packed {
        logic signed [31:0] l_smp;
        logic signed [31:0] r_smp;
        logic               last;
        logic               typed;
        plot_word_t         want;
    } pair_row_t;

    // Rows run with both peaks at their reset value of 1, so any nonzero sample saturates.
    localparam pair_row_t DirectedPairs [16] = '{
        '{32'sd0,    32'sd0,    1'b0, 1'b1, '{1'b0, 7'd0,  8'sd0,  7'd63,  8'sd31,  1'b0}},
        '{32'sd0,    32'sd0,    1'b0, 1'b1, '{1'b1, 7'd63, 8'sd31, 7'd63,  8'sd31,  1'b0}},
        '{32'sd1,    32'sd1,    1'b0, 1'b1, '{1'b0, 7'd0,  8'sd0,  7'd63,  -8'sd8,  1'b0}},
        '{-32'sd1,   -32'sd1,   1'b0, 1'b1, '{1'b0, 7'd0,  8'sd0,  7'd63,  8'sd70,  1'b0}},
        '{SampleMax, SampleMin, 1'b0, 1'b1, '{1'b0, 7'd0,  8'sd0,  7'd102, 8'sd31,  1'b0}},
        '{SampleMin, SampleMax, 1'b0, 1'b1, '{1'b0, 7'd0,  8'sd0,  7'd24,  8'sd31,  1'b0}},
        '{SampleMax, 32'sd0,    1'b0, 1'b1, '{1'b0, 7'd0,  8'sd0,  7'd82,  8'sd12,  1'b0}},
        '{SampleMax, 32'sd0,    1'b1, 1'b1, '{1'b1, 7'd82, 8'sd12, 7'd82,  8'sd12,  1'b1}},
        '{32'sd0,    SampleMax, 1'b0, 1'b1, '{1'b0, 7'd0,  8'sd0,  7'd44,  8'sd12,  1'b0}},
        '{32'sd0,    SampleMin, 1'b0, 1'b1, '{1'b0, 7'd0,  8'sd0,  7'd82,  8'sd50,  1'b0}},
        '{SampleMin, 32'sd0,    1'b0, 1'b1, '{1'b0, 7'd0,  8'sd0,  7'd44,  8'sd50,  1'b0}},
        '{SampleMin, 32'sd0,    1'b0, 1'b1, '{1'b1, 7'd44, 8'sd50, 7'd44,  8'sd50,  1'b0}},
        '{SampleMax, SampleMax, 1'b1, 1'b1, '{1'b0, 7'd0,  8'sd0,  7'd63,  -8'sd8,  1'b1}},
        '{32'sd0,    32'sd0,    1'b1, 1'b1, '{1'b0, 7'd0,  8'sd0,  7'd63,  8'sd31,  1'b1}},
        '{32'sd12345, -32'sd7,  1'b0, 1'b0, '0},
        '{32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, 1'b0, '0}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_index = sgp_pkg::CfgPeakLeft;
    logic [30:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] left_sample = '0;
    logic signed [31:0] right_sample = '0;
    logic               last_in_frame = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               draw_line;
    logic [6:0]         start_x;
    logic signed [7:0]  start_y;
    logic [6:0]         end_x;
    logic signed [7:0]  end_y;
    logic               frame_end;

    // predictor state and register mirror
    logic [30:0]        peak_left_now = 31'd1;
    logic [30:0]        peak_right_now = 31'd1;
    logic               trace_live = 1'b0;
    logic [6:0]         trace_x = '0;
    logic signed [7:0]  trace_y = '0;

    plot_word_t         expected_plots[$];
    int                 error_count = 0;
    int                 cycle_count = 0;
    int                 burst_left = 0;
    int                 stall_mode = 0;
    int unsigned        stall_tick = 0;

    stereo_goniometer_plotter_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .last_in_frame(last_in_frame),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .draw_line    (draw_line),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .frame_end    (frame_end)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Q15 level of one channel, saturated at full scale; a zero peak acts as 1.
    function automatic int norm_q15(logic signed [31:0] s, logic [30:0] pk);
        longint mag;
        longint q;
        mag = s;
        if (mag < 0)
            mag = -mag;
        q = (mag << 15) / ((pk == 0) ? longint'(1) : longint'(pk));
        if (q > QUnit)
            q = QUnit;
        return (s < 0) ? -int'(q) : int'(q);
    endfunction

    // Pixel offset along one rotated axis, truncated toward zero.
    function automatic int axis_offset(int v);
        longint mag;
        mag = (v < 0) ? -longint'(v) : longint'(v);
        mag = (mag * RotGain) >> 30;
        return (v < 0) ? -int'(mag) : int'(mag);
    endfunction

    task automatic predict_plot(input logic signed [31:0] l, input logic signed [31:0] r,
                                input logic last, output plot_word_t w);
        int nl;
        int nr;
        int px;
        int py;
        int dx;
        int dy;
        logic near;
        nl = norm_q15(l, peak_left_now);
        nr = norm_q15(r, peak_right_now);
        px = 63 + axis_offset(nl - nr);
        py = 31 - axis_offset(nl + nr);
        dx = px - int'(trace_x);
        dy = py - int'(trace_y);
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        near = trace_live && (dx + dy <= LineReach);
        w.draw_line = near;
        w.start_x   = near ? trace_x : 7'd0;
        w.start_y   = near ? trace_y : 8'sd0;
        w.end_x     = px[6:0];
        w.end_y     = py[7:0];
        w.frame_end = last;
        trace_live  = !last;
        trace_x     = last ? 7'd0 : px[6:0];
        trace_y     = last ? 8'sd0 : py[7:0];
    endtask

    // Mostly a slow random walk so that lines get drawn; the rest spans the whole field.
    function automatic logic signed [31:0] next_sample(logic [30:0] pk,
                                                       logic signed [31:0] prev);
        longint span;
        longint step;
        longint v;
        logic [63:0] r;
        int sel;
        span = (pk == 0) ? 1 : longint'(pk);
        sel = $urandom_range(0, 9);
        r = {$urandom, $urandom};
        if (sel == 0)
            v = longint'(signed'(r[31:0]));
        else if (sel == 1)
        begin
            case ($urandom_range(0, 4))
                0: v = SampleMax;
                1: v = SampleMin;
                2: v = 0;
                3: v = -1;
                default: v = 1;
            endcase
        end
        else if (sel <= 3)
        begin
            step = span + span / 8;
            v = longint'(r % 64'(2 * step + 1)) - step;
        end
        else
        begin
            step = (span / 8 < 2) ? 2 : span / 8;
            v = longint'(prev) + longint'(r % 64'(2 * step + 1)) - step;
        end
        if (v > longint'(SampleMax))
            v = SampleMax;
        if (v < longint'(SampleMin))
            v = SampleMin;
        return v[31:0];
    endfunction

    // Call at a rising edge; returns at the edge that takes the word.
    task automatic offer_pair(input logic signed [31:0] l, input logic signed [31:0] r,
                              input logic last, input logic typed, input plot_word_t want);
        int gap;
        plot_word_t w;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
        end
        in_valid      <= 1'b1;
        left_sample   <= l;
        right_sample  <= r;
        last_in_frame <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        predict_plot(l, r, last, w);
        expected_plots.push_back(typed ? want : w);
    endtask

    task automatic write_peak(input logic idx, input logic [30:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == sgp_pkg::CfgPeakLeft)
            peak_left_now = value;
        else
            peak_right_now = value;
    endtask

    // Receiver: check each taken word, then pick the next ready on a stall pattern.
    always @(posedge clk)
    begin
        plot_word_t got;
        plot_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{draw_line, start_x, start_y, end_x, end_y, frame_end};
            if (expected_plots.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected plot word %p", got);
            end
            else
            begin
                want = expected_plots.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("plot mismatch: expected %p actual %p", want, got);
                end
            end
        end
        stall_tick++;
        if (stall_tick % 256 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= (stall_tick % 64 >= 40);
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CycleLimit)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        logic signed [31:0] walk_l;
        logic signed [31:0] walk_r;
        logic [30:0] set_l;
        logic [30:0] set_r;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DirectedPairs[i])
            offer_pair(DirectedPairs[i].l_smp, DirectedPairs[i].r_smp, DirectedPairs[i].last,
                       DirectedPairs[i].typed, DirectedPairs[i].want);
        in_valid <= 1'b0;

        walk_l = '0;
        walk_r = '0;
        for (int ph = 0; ph < NumPhases; ph++)
        begin
            // Hold config writes until every word of the previous phase is back.
            while (expected_plots.size() != 0)
                @(posedge clk);
            set_l = peak_left_now;
            set_r = peak_right_now;
            case (ph)
                1:
                begin
                    set_l = PeakMax;
                    set_r = PeakMax;
                end
                2:
                begin
                    set_l = 31'd0;
                    set_r = 31'd0;
                end
                3:
                begin
                    set_l = 31'h0001_0000;
                    set_r = PeakMax;
                end
                4:
                begin
                    set_l = 31'($urandom);
                    set_r = 31'($urandom);
                end
                5:
                begin
                    set_l = 31'd1000;
                    set_r = 31'd3;
                end
                6:
                begin
                    set_l = 31'($urandom_range(1, 70000));
                    set_r = 31'($urandom_range(1, 70000));
                end
                7:
                begin
                    set_l = 31'h4000_0000;
                    set_r = 31'h4000_0000;
                end
                default: ;
            endcase
            if (ph != 0)
            begin
                write_peak(sgp_pkg::CfgPeakLeft, set_l);
                write_peak(sgp_pkg::CfgPeakRight, set_r);
            end
            @(posedge clk);
            for (int n = 0; n < RandPerPhase; n++)
            begin
                walk_l = next_sample(peak_left_now, walk_l);
                walk_r = next_sample(peak_right_now, walk_r);
                offer_pair(walk_l, walk_r, $urandom_range(0, 15) == 0, 1'b0, '0);
            end
            in_valid <= 1'b0;
        end

        while (expected_plots.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
